### sv/sem_pkg.sv
// sem_pkg: shared types and constants of the sobel edge magnitude block
// no dependencies; every other file of the block but sem_stream_if imports it

package sem_pkg;

  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [10:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [12:0] FRAME_HEIGHT_RST = 13'd480;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // largest sum of squares that still rounds to 255
  localparam logic [21:0] MAG_SAT_LIMIT = 22'd65280;

  typedef struct packed {
    logic       cmd;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } sem_in_t;

  typedef struct packed {
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [11:0] out_row;
    logic [9:0]  out_col;
    logic        frame_end;
  } sem_out_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic calc_recv;
    logic calc_total;
    logic store;
    logic decide;
    logic tap_issue;
    logic sq_x;
    logic sq_y;
    logic root_step;
    logic round;
    logic result_taken;
  } sem_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic emit_ok;
    logic tap_last;
    logic root_last;
    logic chan_last;
  } sem_stat_t;

endpackage

### sv/sem_stream_if.sv
// sem_stream_if: valid/ready channel carrying one item of type T
// payload types come from sem_pkg

interface sem_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/sem_ctrl.sv
// sem_ctrl: sequencer for one item at a time
// depends on sem_pkg for the command and status structs

module sem_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  sem_pkg::sem_stat_t  stat,
  output sem_pkg::sem_cmd_t   cmd
);
  import sem_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RECV   = 4'd1;
  localparam logic [3:0] S_TOTAL  = 4'd2;
  localparam logic [3:0] S_STORE  = 4'd3;
  localparam logic [3:0] S_DECIDE = 4'd4;
  localparam logic [3:0] S_TAP    = 4'd5;
  localparam logic [3:0] S_TAPW   = 4'd6;
  localparam logic [3:0] S_SQX    = 4'd7;
  localparam logic [3:0] S_SQY    = 4'd8;
  localparam logic [3:0] S_ROOT   = 4'd9;
  localparam logic [3:0] S_RND    = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          state_next = S_RECV;
        end
      end
      S_RECV: begin
        cmd.calc_recv = 1'b1;
        state_next = S_TOTAL;
      end
      S_TOTAL: begin
        cmd.calc_total = 1'b1;
        state_next = S_STORE;
      end
      S_STORE: begin
        cmd.store = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = stat.emit_ok ? S_TAP : S_IDLE;
      end
      S_TAP: begin
        cmd.tap_issue = 1'b1;
        if (stat.tap_last) begin
          state_next = S_TAPW;
        end
      end
      S_TAPW: begin
        state_next = S_SQX;
      end
      S_SQX: begin
        cmd.sq_x = 1'b1;
        state_next = S_SQY;
      end
      S_SQY: begin
        cmd.sq_y = 1'b1;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (stat.root_last) begin
          state_next = S_RND;
        end
      end
      S_RND: begin
        cmd.round = 1'b1;
        state_next = stat.chan_last ? S_OUT : S_SQX;
      end
      S_OUT: begin
        if (out_ready) begin
          cmd.result_taken = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### sv/sem_dp.sv
// sem_dp: counters, line memory, sobel accumulators and square root unit
// depends on sem_pkg; driven by sem_ctrl commands

module sem_dp #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [sem_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sem_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  sem_pkg::sem_in_t                  in_item,
  input  sem_pkg::sem_cmd_t                 cmd,
  output sem_pkg::sem_stat_t                stat,
  output sem_pkg::sem_out_t                 result
);
  import sem_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int NW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

  logic [10:0]   frame_width;
  logic [12:0]   frame_height;
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;

  sem_in_t       item_q;
  logic [CW-1:0] in_col;
  logic [RW:0]   in_row;
  logic [NW-1:0] received;
  logic [NW-1:0] total;
  logic [NW-1:0] emit_count;
  logic [RW-1:0] emit_row;
  logic [CW-1:0] emit_col;
  logic          last_q;

  logic [23:0]   mem [4][MAX_WIDTH];

  logic [1:0]        tap_i, tap_j;
  logic [RW:0]       rp;
  logic [CW:0]       cp;
  logic              tap_ok;
  logic [1:0]        ra;
  logic [CW-1:0]     ca;
  logic signed [2:0] kx, ky, kx_q, ky_q;
  logic              tap_ok_q, acc_q;
  logic [23:0]       rd_q;
  logic signed [11:0] gx [3];
  logic signed [11:0] gy [3];

  logic [1:0]         ch;
  logic signed [11:0] gsel;
  logic signed [23:0] sqp;
  logic [21:0]        sx, sum;
  logic [16:0]        rem, root, bitv, trial, rnd;
  logic [2:0]         it;
  logic               sat;
  logic [7:0]         mag [3];

  // register limits clamped to 1..max
  always_comb begin
    if (frame_width == '0) begin
      eff_w = WW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(frame_width);
    end
    if (frame_height == '0) begin
      eff_h = HW'(1);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(frame_height);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[10:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  assign stat.emit_ok = (emit_count < total) &&
      ((received >= total) ||
       ((NW+1)'(received) >= (NW+1)'(emit_count) + (NW+1)'(eff_w) + (NW+1)'(2)));
  assign stat.tap_last  = (tap_i == 2'd2) && (tap_j == 2'd2);
  assign stat.root_last = (it == 3'd7);
  assign stat.chan_last = (ch == 2'd2);

  // tap address and mask, neighbors outside the frame count as zero
  always_comb begin
    rp = (RW+1)'(emit_row) + (RW+1)'(tap_i);
    cp = (CW+1)'(emit_col) + (CW+1)'(tap_j);
    tap_ok = (rp != '0) && (32'(rp) <= 32'(eff_h)) &&
             (cp != '0) && (32'(cp) <= 32'(eff_w));
    ra = 2'(rp - (RW+1)'(1));
    ca = tap_ok ? CW'(cp - (CW+1)'(1)) : '0;
    if (tap_j == 2'd0) begin
      kx = (tap_i == 2'd1) ? -3'sd2 : -3'sd1;
    end else if (tap_j == 2'd2) begin
      kx = (tap_i == 2'd1) ? 3'sd2 : 3'sd1;
    end else begin
      kx = 3'sd0;
    end
    if (tap_i == 2'd0) begin
      ky = (tap_j == 2'd1) ? -3'sd2 : -3'sd1;
    end else if (tap_i == 2'd2) begin
      ky = (tap_j == 2'd1) ? 3'sd2 : 3'sd1;
    end else begin
      ky = 3'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store && item_q.cmd == CMD_PIXEL && received < total) begin
      mem[in_row[1:0]][in_col] <= {item_q.red_in, item_q.green_in, item_q.blue_in};
    end
    if (cmd.tap_issue) begin
      rd_q <= mem[ra][ca];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col     <= '0;
      in_row     <= '0;
      received   <= '0;
      total      <= '0;
      emit_count <= '0;
      emit_row   <= '0;
      emit_col   <= '0;
      last_q     <= 1'b0;
      tap_i      <= '0;
      tap_j      <= '0;
      acc_q      <= 1'b0;
      ch         <= '0;
      it         <= '0;
    end else begin
      acc_q <= cmd.tap_issue;
      if (cmd.calc_recv) begin
        received <= NW'(in_row) * NW'(eff_w) + NW'(in_col);
      end
      if (cmd.calc_total) begin
        total <= NW'(eff_w) * NW'(eff_h);
      end
      if (cmd.store && item_q.cmd == CMD_PIXEL && received < total) begin
        received <= received + NW'(1);
        if (32'(in_col) + 1 >= 32'(eff_w)) begin
          in_col <= '0;
          in_row <= in_row + (RW+1)'(1);
        end else begin
          in_col <= in_col + CW'(1);
        end
      end
      if (cmd.decide) begin
        last_q <= (emit_count + NW'(1) == total);
        tap_i  <= '0;
        tap_j  <= '0;
        ch     <= '0;
      end
      if (cmd.tap_issue) begin
        if (tap_j == 2'd2) begin
          tap_j <= '0;
          tap_i <= tap_i + 2'd1;
        end else begin
          tap_j <= tap_j + 2'd1;
        end
      end
      if (cmd.sq_y) begin
        it <= '0;
      end
      if (cmd.root_step) begin
        it <= it + 3'd1;
      end
      if (cmd.round) begin
        ch <= ch + 2'd1;
      end
      if (cmd.result_taken) begin
        if (last_q) begin
          emit_count <= '0;
          emit_row   <= '0;
          emit_col   <= '0;
          in_col     <= '0;
          in_row     <= '0;
        end else begin
          emit_count <= emit_count + NW'(1);
          if (32'(emit_col) + 1 >= 32'(eff_w)) begin
            emit_col <= '0;
            emit_row <= emit_row + RW'(1);
          end else begin
            emit_col <= emit_col + CW'(1);
          end
        end
      end
    end
  end

  // item register; kernel weights accumulate in the cycle after each tap read
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_q <= in_item;
    end
    if (cmd.decide) begin
      for (int c = 0; c < 3; c++) begin
        gx[c] <= '0;
        gy[c] <= '0;
      end
    end
    if (cmd.tap_issue) begin
      tap_ok_q <= tap_ok;
      kx_q     <= kx;
      ky_q     <= ky;
    end
    if (acc_q && tap_ok_q) begin
      for (int c = 0; c < 3; c++) begin
        gx[c] <= gx[c] + signed'({4'b0, rd_q[23-8*c -: 8]}) * 12'(kx_q);
        gy[c] <= gy[c] + signed'({4'b0, rd_q[23-8*c -: 8]}) * 12'(ky_q);
      end
    end
  end

  // squares of one channel, then digit-by-digit integer root
  always_comb begin
    gsel  = cmd.sq_y ? gy[ch] : gx[ch];
    sqp   = gsel * gsel;
    sum   = sx + 22'(sqp);
    bitv  = 17'(1) << (5'd14 - 5'({it, 1'b0}));
    trial = root + bitv;
    rnd   = (rem > root) ? root + 17'd1 : root;
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_x) begin
      sx <= 22'(sqp);
    end
    if (cmd.sq_y) begin
      sat  <= (sum > MAG_SAT_LIMIT);
      rem  <= sum[16:0];
      root <= '0;
    end
    if (cmd.root_step) begin
      if (rem >= trial) begin
        rem  <= rem - trial;
        root <= (root >> 1) + bitv;
      end else begin
        root <= root >> 1;
      end
    end
    if (cmd.round) begin
      mag[ch] <= sat ? 8'd255 : rnd[7:0];
    end
  end

  assign result.red_out   = mag[0];
  assign result.green_out = mag[1];
  assign result.blue_out  = mag[2];
  assign result.out_row   = 12'(emit_row);
  assign result.out_col   = 10'(emit_col);
  assign result.frame_end = last_q;

endmodule

### sv/sobel_edge_magnitude_rgb_unit.sv
// sobel_edge_magnitude_rgb_unit: top level of the sobel edge magnitude block
// depends on sem_pkg, sem_stream_if, sem_ctrl and sem_dp
//
// usage
//   pix_in carries one item per pixel in raster order (cmd pixel) or a flush
//   item (cmd flush) that drains the last row once the frame is complete.
//   res_out carries zero or one result per item: per-channel gradient
//   magnitude with the row and column of the center pixel and a frame end
//   mark on the last result of the frame.
//   frame_width and frame_height are written on the cfg port between items.
// timing
//   one item at a time: ready is high only while the block waits for an item
//   an item without a result passes through recv, total, store and decide
//   an item with a result shows it after bookkeeping (recv, total, store,
//   decide), 9 line memory reads (one read port, one tap per cycle) and a
//   wait state, then per channel squares of x and y, 8 root digits and a round
//   a stalled result holds on res_out; the next item is taken the cycle after
//   the result leaves
// reset
//   synchronous rst clears counters and the sequencer and loads 640 x 480

module sobel_edge_magnitude_rgb_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data,
  sem_stream_if.sink                     pix_in,
  sem_stream_if.source                   res_out
);
  import sem_pkg::*;

  sem_cmd_t  cmd;
  sem_stat_t stat;

  // sequencer: handshakes and step order
  sem_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pix_in.valid),
    .in_ready  (pix_in.ready),
    .out_valid (res_out.valid),
    .out_ready (res_out.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: line memory, window sums, root unit, result registers
  sem_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (pix_in.data),
    .cmd       (cmd),
    .stat      (stat),
    .result    (res_out.data)
  );

endmodule

### sv/sem_checker.sv
// sem_checker: port-level checks of the sobel edge magnitude block
// depends on sem_pkg; bound to sobel_edge_magnitude_rgb_unit

module sem_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input sem_pkg::sem_out_t out_data
);
  import sem_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("item taken while a result waits");

  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid && !in_ready)
    else $error("item finished in one cycle");

  a_out_once: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> !out_valid)
    else $error("result repeated");

endmodule

bind sobel_edge_magnitude_rgb_unit sem_checker u_sem_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pix_in.valid),
  .in_ready  (pix_in.ready),
  .out_valid (res_out.valid),
  .out_ready (res_out.ready),
  .out_data  (res_out.data)
);
